// File: src/ftqg_pkg.sv
// shared types, register indexes, reset values and tier settings table
// for the frame time quality governor; no dependencies
`default_nettype none

package ftqg_pkg;

    localparam int FRAME_W   = 20;
    localparam int AVG_W     = 28;
    localparam int SLOW_W    = 16;
    localparam int FAST_W    = 24;
    localparam int DOWN_W    = 8;
    localparam int ALPHA_W   = 13;
    localparam int CFG_ADR_W = 3;
    localparam int CFG_DAT_W = 20;

    localparam logic [ALPHA_W-1:0] ALPHA_Q16 = 13'd6554;

    localparam logic [CFG_ADR_W-1:0] REG_AUTO_ENABLE = 3'd0;
    localparam logic [CFG_ADR_W-1:0] REG_GAP_LIMIT   = 3'd1;
    localparam logic [CFG_ADR_W-1:0] REG_SLOW_LIMIT  = 3'd2;
    localparam logic [CFG_ADR_W-1:0] REG_FAST_LIMIT  = 3'd3;
    localparam logic [CFG_ADR_W-1:0] REG_SLOW_NEEDED = 3'd4;
    localparam logic [CFG_ADR_W-1:0] REG_FAST_BASE   = 3'd5;

    localparam logic [FRAME_W-1:0] RST_GAP_LIMIT   = 20'd250000;
    localparam logic [FRAME_W-1:0] RST_SLOW_LIMIT  = 20'd26000;
    localparam logic [FRAME_W-1:0] RST_FAST_LIMIT  = 20'd13000;
    localparam logic [SLOW_W-1:0]  RST_SLOW_NEEDED = 16'd90;
    localparam logic [SLOW_W-1:0]  RST_FAST_BASE   = 16'd600;

    typedef struct packed {
        logic               auto_enable;
        logic [FRAME_W-1:0] gap_limit_us;
        logic [FRAME_W-1:0] slow_limit_us;
        logic [FRAME_W-1:0] fast_limit_us;
        logic [SLOW_W-1:0]  slow_frames_needed;
        logic [SLOW_W-1:0]  fast_frames_base;
    } cfg_t;

    // reload of the upgrade threshold when the fast base is written
    typedef struct packed {
        logic              load;
        logic [SLOW_W-1:0] base;
    } need_load_t;

    typedef struct packed {
        logic [12:0] near_size;
        logic [12:0] mid_size;
        logic [12:0] far_size;
        logic [2:0]  bloom;
        logic        dof;
        logic [8:0]  motes_q8;
    } tier_row_t;

    // tiers past the last row use the last row
    function automatic tier_row_t tier_row(input logic [2:0] tier);
        tier_row_t r;
        case (tier)
            3'd0:    r = '{13'd2048, 13'd1024, 13'd1024, 3'd5, 1'b1, 9'd256};
            3'd1:    r = '{13'd1024, 13'd1024, 13'd512,  3'd4, 1'b1, 9'd179};
            3'd2:    r = '{13'd1024, 13'd512,  13'd512,  3'd3, 1'b0, 9'd115};
            default: r = '{13'd768,  13'd512,  13'd512,  3'd2, 1'b0, 9'd51};
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// File: src/ftqg_ema.sv
// frame time average stage: exponential moving average in q8 microseconds
// depends on ftqg_pkg
`default_nettype none

module ftqg_ema (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         load,
    input  wire ftqg_pkg::cfg_t               cfg,
    input  wire logic [ftqg_pkg::FRAME_W-1:0] frame_time_us,
    output logic      [ftqg_pkg::AVG_W-1:0]   average_q8
);

    logic [ftqg_pkg::AVG_W-1:0]                   avg_reg;
    logic [ftqg_pkg::AVG_W-1:0]                   avg_next;
    logic [ftqg_pkg::AVG_W-1:0]                   x_q8;
    logic [ftqg_pkg::AVG_W-1:0]                   mag;
    logic [ftqg_pkg::AVG_W+ftqg_pkg::ALPHA_W-1:0] prod;
    logic [ftqg_pkg::AVG_W-1:0]                   step;
    logic                                         rising;

    always_comb begin
        x_q8   = {frame_time_us, 8'd0};
        rising = (x_q8 >= avg_reg);
        mag    = rising ? (x_q8 - avg_reg) : (avg_reg - x_q8);
        prod   = {{ftqg_pkg::ALPHA_W{1'b0}}, mag} *
                 {{ftqg_pkg::AVG_W{1'b0}}, ftqg_pkg::ALPHA_Q16};
        step   = ftqg_pkg::AVG_W'(prod[ftqg_pkg::AVG_W+ftqg_pkg::ALPHA_W-1:16]);
        avg_next = avg_reg;
        if (cfg.auto_enable && (frame_time_us < cfg.gap_limit_us)) begin
            avg_next = rising ? (avg_reg + step) : (avg_reg - step);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            avg_reg <= '0;
        end else if (load) begin
            avg_reg <= avg_next;
        end
    end

    assign average_q8 = avg_reg;

endmodule

`default_nettype wire

// File: src/ftqg_tier.sv
// tier decision stage: run counters, downgrade count, tier and result register
// depends on ftqg_pkg
`default_nettype none

module ftqg_tier #(
    parameter int NUM_TIERS = 4
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         advance,
    input  wire logic                         m_ready,
    input  wire ftqg_pkg::cfg_t               cfg,
    input  wire ftqg_pkg::need_load_t         need_load,
    input  wire logic [ftqg_pkg::AVG_W-1:0]   average_q8,
    output logic                              m_valid,
    output logic      [1:0]                   m_quality_tier,
    output logic                              m_tier_changed,
    output logic                              m_was_downgrade,
    output logic      [12:0]                  m_shadow_near_size,
    output logic      [12:0]                  m_shadow_mid_size,
    output logic      [12:0]                  m_shadow_far_size,
    output logic      [2:0]                   m_bloom_levels,
    output logic                              m_dof_allowed,
    output logic      [8:0]                   m_motes_fraction_q8,
    output logic      [ftqg_pkg::FRAME_W-1:0] m_smoothed_frame_us
);

    localparam int TW = (NUM_TIERS > 1) ? $clog2(NUM_TIERS) : 1;
    localparam logic [TW-1:0] TIER_LAST = TW'(NUM_TIERS - 1);

    logic [ftqg_pkg::SLOW_W-1:0] slow_run_reg, slow_run_next;
    logic [ftqg_pkg::FAST_W-1:0] fast_run_reg, fast_run_next;
    logic [ftqg_pkg::DOWN_W-1:0] down_cnt_reg, down_cnt_next;
    logic [ftqg_pkg::FAST_W-1:0] need_reg, need_next;
    logic [TW-1:0]               tier_reg, tier_next;
    logic                        changed, downgrade, upgrade, is_slow, is_fast;
    logic [ftqg_pkg::SLOW_W-1:0] slow_inc;
    logic [ftqg_pkg::FAST_W-1:0] fast_inc;
    logic [ftqg_pkg::FAST_W-1:0] need_mult;
    ftqg_pkg::tier_row_t         row;

    logic                        m_valid_reg;
    logic [1:0]                  tier_out_reg;
    logic                        changed_reg, down_reg;
    ftqg_pkg::tier_row_t         row_reg;
    logic [ftqg_pkg::FRAME_W-1:0] smooth_reg;

    always_comb begin
        is_slow  = average_q8 > {cfg.slow_limit_us, 8'd0};
        is_fast  = average_q8 < {cfg.fast_limit_us, 8'd0};
        slow_inc = (&slow_run_reg) ? slow_run_reg : slow_run_reg + 1'b1;
        fast_inc = (&fast_run_reg) ? fast_run_reg : fast_run_reg + 1'b1;

        slow_run_next = slow_run_reg;
        fast_run_next = fast_run_reg;
        down_cnt_next = down_cnt_reg;
        need_next     = need_reg;
        tier_next     = tier_reg;
        downgrade     = 1'b0;
        upgrade       = 1'b0;

        if (cfg.auto_enable) begin
            slow_run_next = is_slow ? slow_inc : '0;
            fast_run_next = (!is_slow && is_fast) ? fast_inc : '0;
            downgrade = (slow_run_next > cfg.slow_frames_needed) && (tier_reg != TIER_LAST);
            upgrade   = !downgrade && (tier_reg != '0) && (fast_run_next > need_reg);
            if (downgrade) begin
                slow_run_next = '0;
                tier_next     = tier_reg + 1'b1;
                if (!(&down_cnt_reg)) begin
                    down_cnt_next = down_cnt_reg + 1'b1;
                    need_next     = need_reg + {8'd0, cfg.fast_frames_base};
                end
            end else if (upgrade) begin
                fast_run_next = '0;
                tier_next     = tier_reg - 1'b1;
            end
        end
        changed = downgrade || upgrade;
        row     = ftqg_pkg::tier_row(3'(tier_next));
    end

    // threshold base * (downgrades + 1), rebuilt when the base is written
    assign need_mult = ftqg_pkg::FAST_W'({need_load.base, 8'd0} >> 8) *
                       ftqg_pkg::FAST_W'({1'b0, down_cnt_reg} + 9'd1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slow_run_reg <= '0;
            fast_run_reg <= '0;
            down_cnt_reg <= '0;
            tier_reg     <= '0;
            need_reg     <= ftqg_pkg::FAST_W'(ftqg_pkg::RST_FAST_BASE);
            m_valid_reg  <= 1'b0;
        end else begin
            if (need_load.load) begin
                need_reg <= need_mult;
            end else if (advance) begin
                need_reg <= need_next;
            end
            if (advance) begin
                slow_run_reg <= slow_run_next;
                fast_run_reg <= fast_run_next;
                down_cnt_reg <= down_cnt_next;
                tier_reg     <= tier_next;
                m_valid_reg  <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg  <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            tier_out_reg <= 2'(tier_next);
            changed_reg  <= changed;
            down_reg     <= downgrade;
            row_reg      <= row;
            smooth_reg   <= average_q8[ftqg_pkg::AVG_W-1:8];
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_quality_tier      = tier_out_reg;
    assign m_tier_changed      = changed_reg;
    assign m_was_downgrade     = down_reg;
    assign m_shadow_near_size  = row_reg.near_size;
    assign m_shadow_mid_size   = row_reg.mid_size;
    assign m_shadow_far_size   = row_reg.far_size;
    assign m_bloom_levels      = row_reg.bloom;
    assign m_dof_allowed       = row_reg.dof;
    assign m_motes_fraction_q8 = row_reg.motes_q8;
    assign m_smoothed_frame_us = smooth_reg;

endmodule

`default_nettype wire

// File: src/frame_time_quality_governor.sv
// top level of the frame time quality governor: config registers and handshake
// depends on ftqg_pkg, ftqg_ema and ftqg_tier
`default_nettype none

// Takes one frame time per word and returns one word with the quality tier and
// its render settings. A new word can be taken every cycle unless the output
// stalls; each word goes through two register stages (the average update, then
// the tier decision into the output register). The average is the only state
// feeding the first stage and the run counters, downgrade count, upgrade
// threshold and tier the only state feeding the second. Configuration
// writes take effect at once and should be made while no word is in flight.

module frame_time_quality_governor #(
    parameter int NUM_TIERS = 4
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_we,
    input  wire logic [ftqg_pkg::CFG_ADR_W-1:0] cfg_addr,
    input  wire logic [ftqg_pkg::CFG_DAT_W-1:0] cfg_wdata,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [ftqg_pkg::FRAME_W-1:0]  s_frame_time_us,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic      [1:0]                    m_quality_tier,
    output logic                               m_tier_changed,
    output logic                               m_was_downgrade,
    output logic      [12:0]                   m_shadow_near_size,
    output logic      [12:0]                   m_shadow_mid_size,
    output logic      [12:0]                   m_shadow_far_size,
    output logic      [2:0]                    m_bloom_levels,
    output logic                               m_dof_allowed,
    output logic      [8:0]                    m_motes_fraction_q8,
    output logic      [ftqg_pkg::FRAME_W-1:0]  m_smoothed_frame_us
);

    ftqg_pkg::cfg_t       cfg_reg;
    ftqg_pkg::need_load_t need_load;
    logic                 stage_valid_reg;
    logic                 advance;
    logic                 load;
    logic [ftqg_pkg::AVG_W-1:0] average_q8;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.auto_enable        <= 1'b1;
            cfg_reg.gap_limit_us       <= ftqg_pkg::RST_GAP_LIMIT;
            cfg_reg.slow_limit_us      <= ftqg_pkg::RST_SLOW_LIMIT;
            cfg_reg.fast_limit_us      <= ftqg_pkg::RST_FAST_LIMIT;
            cfg_reg.slow_frames_needed <= ftqg_pkg::RST_SLOW_NEEDED;
            cfg_reg.fast_frames_base   <= ftqg_pkg::RST_FAST_BASE;
        end else if (cfg_we) begin
            case (cfg_addr)
                ftqg_pkg::REG_AUTO_ENABLE: cfg_reg.auto_enable        <= cfg_wdata[0];
                ftqg_pkg::REG_GAP_LIMIT:   cfg_reg.gap_limit_us       <= cfg_wdata;
                ftqg_pkg::REG_SLOW_LIMIT:  cfg_reg.slow_limit_us      <= cfg_wdata;
                ftqg_pkg::REG_FAST_LIMIT:  cfg_reg.fast_limit_us      <= cfg_wdata;
                ftqg_pkg::REG_SLOW_NEEDED: cfg_reg.slow_frames_needed <= cfg_wdata[15:0];
                ftqg_pkg::REG_FAST_BASE:   cfg_reg.fast_frames_base   <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    assign need_load.load = cfg_we && (cfg_addr == ftqg_pkg::REG_FAST_BASE);
    assign need_load.base = cfg_wdata[15:0];

    // second stage moves when the output register is free or being emptied
    assign advance = stage_valid_reg && (!m_valid || m_ready);
    assign s_ready = !stage_valid_reg || advance;
    assign load    = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_valid_reg <= 1'b0;
        end else if (load) begin
            stage_valid_reg <= 1'b1;
        end else if (advance) begin
            stage_valid_reg <= 1'b0;
        end
    end

    ftqg_ema u_ema (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .load          (load),
        .cfg           (cfg_reg),
        .frame_time_us (s_frame_time_us),
        .average_q8    (average_q8)
    );

    ftqg_tier #(
        .NUM_TIERS (NUM_TIERS)
    ) u_tier (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .advance             (advance),
        .m_ready             (m_ready),
        .cfg                 (cfg_reg),
        .need_load           (need_load),
        .average_q8          (average_q8),
        .m_valid             (m_valid),
        .m_quality_tier      (m_quality_tier),
        .m_tier_changed      (m_tier_changed),
        .m_was_downgrade     (m_was_downgrade),
        .m_shadow_near_size  (m_shadow_near_size),
        .m_shadow_mid_size   (m_shadow_mid_size),
        .m_shadow_far_size   (m_shadow_far_size),
        .m_bloom_levels      (m_bloom_levels),
        .m_dof_allowed       (m_dof_allowed),
        .m_motes_fraction_q8 (m_motes_fraction_q8),
        .m_smoothed_frame_us (m_smoothed_frame_us)
    );

endmodule

`default_nettype wire

// File: tb/tb.sv
// testbench for frame_time_quality_governor: drives frame time words, predicts each
// tier word from a cycle-free model of the governor and compares every field
// depends on ftqg_pkg and the governor rtl
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_TIERS = 4;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_LIMIT = 5000;
    localparam logic [63:0] ALPHA = 64'd6554;
    localparam logic [ftqg_pkg::CFG_ADR_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [ftqg_pkg::CFG_ADR_W-1:0] REG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [1:0]  tier;
        logic        changed;
        logic        downgrade;
        logic [12:0] near_size;
        logic [12:0] mid_size;
        logic [12:0] far_size;
        logic [2:0]  bloom;
        logic        dof;
        logic [8:0]  motes_q8;
        logic [19:0] smoothed_us;
    } tier_word_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [ftqg_pkg::CFG_ADR_W-1:0] cfg_addr = '0;
    logic [ftqg_pkg::CFG_DAT_W-1:0] cfg_wdata = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [ftqg_pkg::FRAME_W-1:0] s_frame_time_us = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [1:0] m_quality_tier;
    logic m_tier_changed;
    logic m_was_downgrade;
    logic [12:0] m_shadow_near_size;
    logic [12:0] m_shadow_mid_size;
    logic [12:0] m_shadow_far_size;
    logic [2:0] m_bloom_levels;
    logic m_dof_allowed;
    logic [8:0] m_motes_fraction_q8;
    logic [ftqg_pkg::FRAME_W-1:0] m_smoothed_frame_us;

    ftqg_pkg::cfg_t regs;
    logic [ftqg_pkg::AVG_W-1:0] avg_q8;
    logic [ftqg_pkg::SLOW_W-1:0] slow_run;
    logic [ftqg_pkg::FAST_W-1:0] fast_run;
    logic [ftqg_pkg::DOWN_W-1:0] downgrades;
    int unsigned tier;

    tier_word_t tier_words_due[$];
    int mismatches = 0;
    bit src_gaps_on = 1'b1;
    bit sink_gaps_on = 1'b1;
    bit hold_off_req = 1'b0;
    bit hold_active = 1'b0;
    int burst_left = 0;
    int burst_level = 0;

    frame_time_quality_governor #(.NUM_TIERS(NUM_TIERS)) i_dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_we              (cfg_we),
        .cfg_addr            (cfg_addr),
        .cfg_wdata           (cfg_wdata),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_frame_time_us     (s_frame_time_us),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_quality_tier      (m_quality_tier),
        .m_tier_changed      (m_tier_changed),
        .m_was_downgrade     (m_was_downgrade),
        .m_shadow_near_size  (m_shadow_near_size),
        .m_shadow_mid_size   (m_shadow_mid_size),
        .m_shadow_far_size   (m_shadow_far_size),
        .m_bloom_levels      (m_bloom_levels),
        .m_dof_allowed       (m_dof_allowed),
        .m_motes_fraction_q8 (m_motes_fraction_q8),
        .m_smoothed_frame_us (m_smoothed_frame_us)
    );

    always #10 aclk = ~aclk;

    function automatic int gap_len(input bit enabled);
        int r;
        if (!enabled) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [ftqg_pkg::AVG_W-1:0] ema_next(
        input logic [ftqg_pkg::AVG_W-1:0] avg,
        input logic [ftqg_pkg::FRAME_W-1:0] frame);
        logic [63:0] x, a, step;
        x = 64'(frame) << 8;
        a = 64'(avg);
        if (x >= a) begin
            step = ((x - a) * ALPHA) >> 16;
            a = a + step;
        end else begin
            step = ((a - x) * ALPHA) >> 16;
            a = a - step;
        end
        return a[ftqg_pkg::AVG_W-1:0];
    endfunction

    function automatic logic [51:0] row_settings(input int unsigned row);
        case (row)
            0:       return {13'd2048, 13'd1024, 13'd1024, 3'd5, 1'b1, 9'd256};
            1:       return {13'd1024, 13'd1024, 13'd512, 3'd4, 1'b1, 9'd179};
            2:       return {13'd1024, 13'd512, 13'd512, 3'd3, 1'b0, 9'd115};
            default: return {13'd768, 13'd512, 13'd512, 3'd2, 1'b0, 9'd51};
        endcase
    endfunction

    task automatic step_governor(input logic [ftqg_pkg::FRAME_W-1:0] frame,
                                 output tier_word_t w);
        logic [63:0] slow_q8, fast_q8, need_fast;
        int unsigned row;
        w = '0;
        if (regs.auto_enable) begin
            slow_q8 = 64'(regs.slow_limit_us) << 8;
            fast_q8 = 64'(regs.fast_limit_us) << 8;
            if (frame < regs.gap_limit_us) avg_q8 = ema_next(avg_q8, frame);
            if (64'(avg_q8) > slow_q8) begin
                if (slow_run != '1) slow_run++;
                fast_run = '0;
            end else if (64'(avg_q8) < fast_q8) begin
                if (fast_run != '1) fast_run++;
                slow_run = '0;
            end else begin
                slow_run = '0;
                fast_run = '0;
            end
            need_fast = 64'(regs.fast_frames_base) * (64'(downgrades) + 64'd1);
            if (slow_run > regs.slow_frames_needed && tier < NUM_TIERS - 1) begin
                slow_run = '0;
                if (downgrades != '1) downgrades++;
                tier++;
                w.changed = 1'b1;
                w.downgrade = 1'b1;
            end else if (tier > 0 && 64'(fast_run) > need_fast) begin
                fast_run = '0;
                tier--;
                w.changed = 1'b1;
            end
        end
        row = (tier < 4) ? tier : 3;
        w.tier = tier[1:0];
        {w.near_size, w.mid_size, w.far_size, w.bloom, w.dof, w.motes_q8} = row_settings(row);
        w.smoothed_us = avg_q8[ftqg_pkg::AVG_W-1:8];
    endtask

    function automatic string word_text(input tier_word_t w);
        return $sformatf({"tier %0d chg %0b down %0b shadow %0d/%0d/%0d ",
                          "bloom %0d dof %0b motes %0d avg %0d"},
                         w.tier, w.changed, w.downgrade, w.near_size, w.mid_size, w.far_size,
                         w.bloom, w.dof, w.motes_q8, w.smoothed_us);
    endfunction

    task automatic report_mismatch(input string what, input tier_word_t exp_w,
                                   input tier_word_t got_w);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%0t: %s", $time, what);
            $display("  expected %s", word_text(exp_w));
            $display("  actual   %s", word_text(got_w));
        end
    endtask

    task automatic write_reg(input logic [ftqg_pkg::CFG_ADR_W-1:0] idx,
                             input logic [ftqg_pkg::CFG_DAT_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        case (idx)
            ftqg_pkg::REG_AUTO_ENABLE: regs.auto_enable = value[0];
            ftqg_pkg::REG_GAP_LIMIT:   regs.gap_limit_us = value;
            ftqg_pkg::REG_SLOW_LIMIT:  regs.slow_limit_us = value;
            ftqg_pkg::REG_FAST_LIMIT:  regs.fast_limit_us = value;
            ftqg_pkg::REG_SLOW_NEEDED: regs.slow_frames_needed = value[ftqg_pkg::SLOW_W-1:0];
            ftqg_pkg::REG_FAST_BASE:   regs.fast_frames_base = value[ftqg_pkg::SLOW_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [19:0] en, input logic [19:0] gap,
                              input logic [19:0] slow, input logic [19:0] fast,
                              input logic [19:0] needed, input logic [19:0] base);
        write_reg(ftqg_pkg::REG_AUTO_ENABLE, en);
        write_reg(ftqg_pkg::REG_GAP_LIMIT, gap);
        write_reg(ftqg_pkg::REG_SLOW_LIMIT, slow);
        write_reg(ftqg_pkg::REG_FAST_LIMIT, fast);
        write_reg(ftqg_pkg::REG_SLOW_NEEDED, needed);
        write_reg(ftqg_pkg::REG_FAST_BASE, base);
        cfg_we <= 1'b0;
    endtask

    task automatic send_frame(input logic [ftqg_pkg::FRAME_W-1:0] frame);
        tier_word_t w;
        int n;
        n = gap_len(src_gaps_on);
        if (n > 0) begin
            s_valid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_frame_time_us <= frame;
        do @(posedge aclk); while (!s_ready);
        step_governor(frame, w);
        tier_words_due.push_back(w);
    endtask

    task automatic drain();
        int waited;
        waited = 0;
        s_valid <= 1'b0;
        while (tier_words_due.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (4) @(posedge aclk);
    endtask

    task automatic pick_frame(output logic [ftqg_pkg::FRAME_W-1:0] f);
        int r;
        if (burst_left == 0) begin
            burst_left = $urandom_range(3, 25);
            case ($urandom_range(0, 2))
                0:       burst_level = $urandom_range(0, 8000);
                1:       burst_level = $urandom_range(10000, 25000);
                default: burst_level = $urandom_range(30000, 90000);
            endcase
        end
        burst_left--;
        r = $urandom_range(0, 99);
        if (r < 5) begin
            f = 20'($urandom_range(0, 20'hFFFFF));
        end else if (r < 9) begin
            f = regs.gap_limit_us;
            if (f != 20'hFFFFF && $urandom_range(0, 1) == 1) f = f + 20'd1;
        end else if (r < 11) begin
            f = regs.gap_limit_us - 20'd1;
        end else begin
            f = 20'(burst_level + $urandom_range(0, 2000));
        end
    endtask

    function automatic logic [19:0] pick_reg(input logic [19:0] top, input int unsigned lo,
                                             input int unsigned hi);
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0) return 20'd0;
        if (r == 1) return top;
        return 20'($urandom_range(lo, hi));
    endfunction

    task automatic test_reset_values();
        send_frame(20'd0);
        send_frame(20'hFFFFF);
        send_frame(ftqg_pkg::RST_GAP_LIMIT);
        send_frame(ftqg_pkg::RST_GAP_LIMIT - 20'd1);
        send_frame(20'd16667);
    endtask

    task automatic test_disable_and_spare_writes();
        drain();
        write_reg(ftqg_pkg::REG_AUTO_ENABLE, 20'hFFFFE);
        write_reg(REG_SPARE_LO, 20'd0);
        write_reg(REG_SPARE_HI, 20'd0);
        cfg_we <= 1'b0;
        send_frame(20'd30000);
        send_frame(20'd5);
    endtask

    task automatic test_tier_walk();
        drain();
        write_reg(ftqg_pkg::REG_AUTO_ENABLE, 20'h00001);
        write_reg(ftqg_pkg::REG_GAP_LIMIT, 20'hFFFFF);
        write_reg(ftqg_pkg::REG_SLOW_LIMIT, 20'd100);
        write_reg(ftqg_pkg::REG_FAST_LIMIT, 20'd0);
        write_reg(ftqg_pkg::REG_SLOW_NEEDED, 20'hF0001);
        write_reg(ftqg_pkg::REG_FAST_BASE, 20'hF0000);
        cfg_we <= 1'b0;
        // two slow words per step down, the sixth hits the bottom tier and the last stays there
        repeat (7) send_frame(20'hFFFFE);
        drain();
        write_reg(ftqg_pkg::REG_SLOW_LIMIT, 20'hFFFFF);
        write_reg(ftqg_pkg::REG_FAST_LIMIT, 20'hFFFFF);
        cfg_we <= 1'b0;
        repeat (4) send_frame(20'd0);
    endtask

    task automatic test_output_backpressure();
        logic [ftqg_pkg::FRAME_W-1:0] f;
        drain();
        hold_off_req = 1'b1;
        while (!hold_active) @(posedge aclk);
        src_gaps_on = 1'b0;
        repeat (40) begin
            pick_frame(f);
            send_frame(f);
        end
        src_gaps_on = 1'b1;
    endtask

    task automatic test_random_phases();
        logic [ftqg_pkg::FRAME_W-1:0] f;
        logic [19:0] en, gap, slow, fast, needed, base;
        for (int phase = 0; phase < 5; phase++) begin
            drain();
            en = {19'($urandom()), ($urandom_range(0, 9) != 0)};
            gap = pick_reg(20'hFFFFF, 20000, 300000);
            slow = pick_reg(20'hFFFFF, 8000, 30000);
            fast = pick_reg(20'hFFFFF, 4000, 26000);
            needed = pick_reg(20'hFFFF, 1, 12) | (20'($urandom_range(0, 15)) << 16);
            base = pick_reg(20'hFFFF, 1, 8) | (20'($urandom_range(0, 15)) << 16);
            set_config(en, gap, slow, fast, needed, base);
            src_gaps_on = (phase % 3 != 2);
            sink_gaps_on = (phase % 4 != 3);
            repeat (40) begin
                pick_frame(f);
                send_frame(f);
            end
        end
        src_gaps_on = 1'b1;
        sink_gaps_on = 1'b1;
    endtask

    task automatic test_repeated_downgrades();
        drain();
        set_config(20'd1, 20'hFFFFF, 20'd1000, 20'd1000, 20'd0, 20'd0);
        // steer the average back and forth across the shared limit so the tier moves down and up repeatedly
        repeat (100) send_frame((avg_q8 > 28'd256000) ? 20'd0 : 20'd2000);
        drain();
        write_reg(ftqg_pkg::REG_FAST_BASE, 20'd1);
        cfg_we <= 1'b0;
        for (int k = 0; k < 50 && tier == 0; k++) send_frame(20'd2000);
        repeat (80) send_frame(20'd0);
    endtask

    task automatic test_long_slow_run();
        drain();
        src_gaps_on = 1'b0;
        sink_gaps_on = 1'b0;
        set_config(20'd1, 20'hFFFFF, 20'd0, 20'd0, 20'hFFFF, 20'd600);
        repeat (20) send_frame(20'd1000);
        drain();
        write_reg(ftqg_pkg::REG_SLOW_NEEDED, 20'd10);
        cfg_we <= 1'b0;
        repeat (3) send_frame(20'd1000);
        src_gaps_on = 1'b1;
        sink_gaps_on = 1'b1;
    endtask

    initial begin : sink
        int n;
        @(posedge aclk);
        forever begin
            if (hold_off_req) begin
                hold_active = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_off_req = 1'b0;
                hold_active = 1'b0;
            end else begin
                n = gap_len(sink_gaps_on);
                if (n > 0) begin
                    m_ready <= 1'b0;
                    repeat (n) @(posedge aclk);
                end
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
    end

    always @(posedge aclk) begin : word_check
        tier_word_t got, exp_w;
        if (aresetn && m_valid && m_ready) begin
            got = {m_quality_tier, m_tier_changed, m_was_downgrade, m_shadow_near_size,
                   m_shadow_mid_size, m_shadow_far_size, m_bloom_levels, m_dof_allowed,
                   m_motes_fraction_q8, m_smoothed_frame_us};
            if (tier_words_due.size() == 0) begin
                report_mismatch("word with nothing expected", '0, got);
            end else begin
                exp_w = tier_words_due.pop_front();
                if (got !== exp_w) report_mismatch("tier word mismatch", exp_w, got);
            end
        end
    end

    initial begin
        regs = '{1'b1, ftqg_pkg::RST_GAP_LIMIT, ftqg_pkg::RST_SLOW_LIMIT,
                 ftqg_pkg::RST_FAST_LIMIT, ftqg_pkg::RST_SLOW_NEEDED,
                 ftqg_pkg::RST_FAST_BASE};
        avg_q8 = '0;
        slow_run = '0;
        fast_run = '0;
        downgrades = '0;
        tier = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_values();
        test_disable_and_spare_writes();
        test_tier_walk();
        test_output_backpressure();
        test_random_phases();
        test_repeated_downgrades();
        test_long_slow_run();
        drain();
        if (mismatches == 0 && tier_words_due.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #(64'd20_000_000);
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: files.f
src/ftqg_pkg.sv
src/ftqg_ema.sv
src/ftqg_tier.sv
src/frame_time_quality_governor.sv
tb/tb.sv
